### design/rsf_pkg.sv
// ----------------------------------------------------------------------------
// rsf_pkg: shared constants of the ranging sample filter chain
// Field widths, fixed-point scales, register map and register reset values.
// ----------------------------------------------------------------------------
package rsf_pkg;

    // Field widths
    localparam int CH_W   = 2;
    localparam int BYTE_W = 8;
    localparam int RAW_W  = 16;
    localparam int DIST_W = 24;
    localparam int COV_W  = 18;
    localparam int DEN_W  = COV_W + 1;
    localparam int K_W    = 17;
    localparam int W_W    = 9;
    localparam int WL_W   = 4;
    localparam int PROD_W = K_W + DIST_W;
    localparam int Q16_SH = 16;
    localparam int BLEND_SH = 8;
    localparam int MWIDE_W = 40;

    // Fixed-point constants
    localparam logic [DIST_W-1:0] DIST_SAT = '1;
    localparam logic [K_W-1:0]    ONE_Q16  = 17'h10000;
    localparam logic [W_W-1:0]    W_ONE    = 9'd256;

    // APB port
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;
    localparam int IDX_W  = APB_AW - 2;

    // Register map
    localparam logic [IDX_W-1:0] REG_PROC_NOISE = 3'd0;
    localparam logic [IDX_W-1:0] REG_MEAS_NOISE = 3'd1;
    localparam logic [IDX_W-1:0] REG_WIN_LEN    = 3'd2;
    localparam logic [IDX_W-1:0] REG_RAW_WEIGHT = 3'd3;
    localparam logic [IDX_W-1:0] REG_MIN_DIST   = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_DIST   = 3'd5;

    // Register reset values
    localparam logic [RAW_W-1:0] RST_PROC_NOISE = 16'd65;
    localparam logic [RAW_W-1:0] RST_MEAS_NOISE = 16'd66;
    localparam logic [WL_W-1:0]  RST_WIN_LEN    = 4'd3;
    localparam logic [W_W-1:0]   RST_RAW_WEIGHT = 9'd84;
    localparam logic [RAW_W-1:0] RST_MIN_DIST   = 16'd27;
    localparam logic [RAW_W-1:0] RST_MAX_DIST   = 16'd4500;

endpackage

### design/rsf_ram.sv
// ----------------------------------------------------------------------------
// rsf_ram: generic single-write, single-read memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rsf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/rsf_div.sv
// ----------------------------------------------------------------------------
// rsf_div: iterative restoring divider
// One quotient bit per cycle. The dividend is loaded left-aligned with an
// optional partial remainder; the quotient collects in the low i_steps bits.
// ----------------------------------------------------------------------------
module rsf_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 19
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [$clog2(NUM_W+1)-1:0]   i_steps,
    input  logic [DEN_W-1:0]             i_rem,
    input  logic [NUM_W-1:0]             i_num,
    input  logic [DEN_W-1:0]             i_den,
    output logic                         o_done,
    output logic [NUM_W-1:0]             o_quo
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [NUM_W-1:0]  r_num;

    logic [DEN_W:0]    cand;
    logic [DEN_W:0]    trial;
    logic              fits;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        cand  = {r_rem, r_num[NUM_W-1]};
        trial = cand - {1'b0, r_den};
        fits  = (cand >= {1'b0, r_den});
    end

    // Sequence the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? trial[DEN_W-1:0] : cand[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

### design/range_sample_filter_chain.sv
// ----------------------------------------------------------------------------
// range_sample_filter_chain: per-channel ranging filter
// Decodes a two-byte frame, runs a scalar Kalman update, a moving average
// and a raw/average blend, all on one shared multiplier and one divider.
// ----------------------------------------------------------------------------
// Sequence: an in-range frame runs decode, the gain division (17 gain bits), the estimate
//   and covariance updates, the window update, the average division (SUM_W bits), the blend
//   and output; a rejected frame goes straight to output, waiting there on a stalled result.
// Handshake: one request at a time; ready returns at the edge that loads the output
//   register.
// Reset: synchronous, active low; a clearing pass then zeroes all 2**ADDR_W window slots first.
module range_sample_filter_chain #(
    parameter int NUM_CHANNELS = 4,
    parameter int WINDOW_MAX   = 8,
    parameter int FRAC_BITS    = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [rsf_pkg::CH_W-1:0]     i_channel,
    input  logic [rsf_pkg::BYTE_W-1:0]   i_first_byte,
    input  logic [rsf_pkg::BYTE_W-1:0]   i_second_byte,
    // result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rsf_pkg::CH_W-1:0]     o_out_channel,
    output logic [rsf_pkg::DIST_W-1:0]   o_held_distance,
    output logic                         o_sample_accepted,
    output logic                         o_bytes_swapped,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rsf_pkg::APB_AW-1:0]   paddr,
    input  logic [rsf_pkg::APB_DW-1:0]   pwdata,
    output logic [rsf_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    import rsf_pkg::*;

    localparam int NCH      = (NUM_CHANNELS < (2 ** CH_W)) ? NUM_CHANNELS : (2 ** CH_W);
    localparam int CH_IDX_W = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int POS_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W    = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W    = DIST_W + LEN_W;
    localparam int ADDR_W   = CH_IDX_W + POS_W;
    localparam int STEP_W   = $clog2(SUM_W + 1);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_DECODE = 12'b0000_0000_0100,
        S_KDIV   = 12'b0000_0000_1000,
        S_EST    = 12'b0000_0001_0000,
        S_COV    = 12'b0000_0010_0000,
        S_WIN    = 12'b0000_0100_0000,
        S_AVG    = 12'b0000_1000_0000,
        S_BL1    = 12'b0001_0000_0000,
        S_BL2    = 12'b0010_0000_0000,
        S_BL3    = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [RAW_W-1:0] r_pns, r_mns, r_dmin, r_dmax;
    logic [WL_W-1:0]  r_wlen;
    logic [W_W-1:0]   r_rw;

    // per-channel state
    logic [DIST_W-1:0] r_est  [NCH];
    logic [COV_W-1:0]  r_cov  [NCH];
    logic [SUM_W-1:0]  r_sum  [NCH];
    logic [POS_W-1:0]  r_pos  [NCH];
    logic [DIST_W-1:0] r_held [NCH];

    // request and working registers
    logic [CH_W-1:0]   r_ch;
    logic [BYTE_W-1:0] r_b0, r_b1;
    logic [DIST_W-1:0] r_m, r_diff, r_xn, r_avg;
    logic              r_up, r_den_zero;
    logic [COV_W-1:0]  r_pp;
    logic [K_W-1:0]    r_k;
    logic [PROD_W-1:0] r_prod;
    logic [31:0]       r_acc;
    logic [POS_W-1:0]  r_wpos;
    logic [ADDR_W-1:0] r_addr, r_clr_addr;

    // result staging and output register
    logic [DIST_W-1:0] r_res_held, r_o_held;
    logic [CH_W-1:0]   r_o_ch;
    logic              r_res_acc, r_res_sw, r_o_acc, r_o_sw, r_o_valid;

    // window store port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DIST_W-1:0] ram_wdata, ram_rdata;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic             cfg_wr;
    logic [IDX_W-1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[APB_AW-1:2];

    // Return the addressed register
    always_comb begin
        unique case (cfg_idx)
            REG_PROC_NOISE: prdata = APB_DW'(r_pns);
            REG_MEAS_NOISE: prdata = APB_DW'(r_mns);
            REG_WIN_LEN:    prdata = APB_DW'(r_wlen);
            REG_RAW_WEIGHT: prdata = APB_DW'(r_rw);
            REG_MIN_DIST:   prdata = APB_DW'(r_dmin);
            REG_MAX_DIST:   prdata = APB_DW'(r_dmax);
            default:        prdata = '0;
        endcase
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pns  <= RST_PROC_NOISE;
            r_mns  <= RST_MEAS_NOISE;
            r_wlen <= RST_WIN_LEN;
            r_rw   <= RST_RAW_WEIGHT;
            r_dmin <= RST_MIN_DIST;
            r_dmax <= RST_MAX_DIST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PROC_NOISE: r_pns  <= pwdata[RAW_W-1:0];
                REG_MEAS_NOISE: r_mns  <= pwdata[RAW_W-1:0];
                REG_WIN_LEN:    r_wlen <= pwdata[WL_W-1:0];
                REG_RAW_WEIGHT: r_rw   <= pwdata[W_W-1:0];
                REG_MIN_DIST:   r_dmin <= pwdata[RAW_W-1:0];
                REG_MAX_DIST:   r_dmax <= pwdata[RAW_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame decode and filter set-up
    // ------------------------------------------------------------------
    logic [CH_IDX_W-1:0] ch_idx;
    logic                ch_ok, le_ok, sw_ok, smp_ok;
    logic [RAW_W-1:0]    d_le, d_sw, smp;
    logic [MWIDE_W-1:0]  m_wide;
    logic [DIST_W-1:0]   m_sat, x_cur, x_new;
    logic [DEN_W-1:0]    pp_sum, den;
    logic [COV_W-1:0]    pp;
    logic [LEN_W-1:0]    len_eff, pos_inc;
    logic [POS_W-1:0]    pos_cur, pos_adj, pos_nxt;
    logic [W_W-1:0]      w_eff;
    logic [SUM_W-1:0]    sum_new;
    logic [31:0]         blend;

    assign ch_idx = r_ch[CH_IDX_W-1:0];
    assign ch_ok  = (32'(r_ch) < 32'(NCH));
    assign x_cur  = r_est[ch_idx];

    // Try little-endian first, then swapped
    always_comb begin
        d_le   = {r_b1, r_b0};
        d_sw   = {r_b0, r_b1};
        le_ok  = (d_le >= r_dmin) && (d_le <= r_dmax);
        sw_ok  = (d_sw >= r_dmin) && (d_sw <= r_dmax);
        smp_ok = le_ok | sw_ok;
        smp    = le_ok ? d_le : d_sw;
        m_wide = MWIDE_W'(smp) << FRAC_BITS;
        m_sat  = (|m_wide[MWIDE_W-1:DIST_W]) ? DIST_SAT : m_wide[DIST_W-1:0];
    end

    // Predict covariance, saturate, form the gain divisor
    always_comb begin
        pp_sum = DEN_W'(r_cov[ch_idx]) + DEN_W'(r_pns);
        pp     = pp_sum[DEN_W-1] ? '1 : pp_sum[COV_W-1:0];
        den    = DEN_W'(pp) + DEN_W'(r_mns);
    end

    // Clamp window length and raw weight
    always_comb begin
        if (r_wlen == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(r_wlen) > 32'(WINDOW_MAX)) begin
            len_eff = LEN_W'(WINDOW_MAX);
        end else begin
            len_eff = LEN_W'(r_wlen);
        end
        w_eff   = (r_rw > W_ONE) ? W_ONE : r_rw;
        pos_cur = r_pos[ch_idx];
        pos_adj = (LEN_W'(pos_cur) >= len_eff) ? '0 : pos_cur;
        pos_inc = LEN_W'(r_wpos) + LEN_W'(1);
        pos_nxt = (pos_inc >= len_eff) ? '0 : r_wpos + POS_W'(1);
    end

    // Estimate step, window sum and blend
    always_comb begin
        x_new   = r_up ? (x_cur + r_prod[Q16_SH+DIST_W-1:Q16_SH])
                       : (x_cur - r_prod[Q16_SH+DIST_W-1:Q16_SH]);
        sum_new = r_sum[ch_idx] - SUM_W'(ram_rdata) + SUM_W'(r_xn);
        blend   = r_acc + r_prod[31:0];
    end

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    logic [K_W-1:0]    mul_a;
    logic [DIST_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;

    always_comb begin
        unique case (r_state)
            S_EST: begin
                mul_a = r_k;
                mul_b = r_diff;
            end
            S_COV: begin
                mul_a = ONE_Q16 - r_k;
                mul_b = DIST_W'(r_pp);
            end
            S_BL1: begin
                mul_a = K_W'(w_eff);
                mul_b = r_m;
            end
            S_BL2: begin
                mul_a = K_W'(W_ONE - w_eff);
                mul_b = r_avg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // ------------------------------------------------------------------
    // Shared divider: gain, then window average
    // ------------------------------------------------------------------
    logic              div_start, div_done;
    logic [STEP_W-1:0] div_steps;
    logic [DEN_W-1:0]  div_rem, div_den;
    logic [SUM_W-1:0]  div_num, div_quo;
    logic [K_W-1:0]    k_quo;

    always_comb begin
        div_start = 1'b0;
        div_steps = STEP_W'(SUM_W);
        div_rem   = '0;
        div_num   = sum_new;
        div_den   = DEN_W'(len_eff);
        if (r_state == S_DECODE) begin
            div_start = ch_ok & smp_ok;
            div_steps = STEP_W'(K_W);
            div_rem   = DEN_W'(pp >> 1);
            div_num   = SUM_W'({pp[0], 16'b0}) << (SUM_W - K_W);
            div_den   = den;
        end else if (r_state == S_WIN) begin
            div_start = 1'b1;
        end
        k_quo = div_quo[K_W-1:0];
    end

    rsf_div #(
        .NUM_W (SUM_W),
        .DEN_W (DEN_W)
    ) u_rsf_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_steps (div_steps),
        .i_rem   (div_rem),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // ------------------------------------------------------------------
    // Window store
    // ------------------------------------------------------------------
    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_WIN);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : r_xn;

    rsf_ram #(
        .WIDTH (DIST_W),
        .DEPTH (2 ** ADDR_W)
    ) u_rsf_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic out_load;

    assign o_ready  = (r_state == S_IDLE);
    assign out_load = (r_state == S_OUT) && (!r_o_valid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_clr_addr == '1) n_state = S_IDLE;
            S_IDLE:   if (i_valid) n_state = S_DECODE;
            S_DECODE: n_state = (ch_ok && smp_ok) ? S_KDIV : S_OUT;
            S_KDIV:   if (div_done) n_state = S_EST;
            S_EST:    n_state = S_COV;
            S_COV:    n_state = S_WIN;
            S_WIN:    n_state = S_AVG;
            S_AVG:    if (div_done) n_state = S_BL1;
            S_BL1:    n_state = S_BL2;
            S_BL2:    n_state = S_BL3;
            S_BL3:    n_state = S_OUT;
            S_OUT:    if (out_load) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // Control state: sequencer, sweep, per-channel filter state, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_o_valid  <= 1'b0;
            for (int i = 0; i < NCH; i++) begin
                r_est[i]  <= '0;
                r_cov[i]  <= COV_W'(ONE_Q16);
                r_sum[i]  <= '0;
                r_pos[i]  <= '0;
                r_held[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (r_state == S_COV) begin
                r_est[ch_idx] <= x_new;
            end
            if (r_state == S_WIN) begin
                r_cov[ch_idx] <= r_prod[Q16_SH+COV_W-1:Q16_SH];
                r_sum[ch_idx] <= sum_new;
                r_pos[ch_idx] <= pos_nxt;
            end
            if (r_state == S_BL3) begin
                r_held[ch_idx] <= blend[BLEND_SH+DIST_W-1:BLEND_SH];
            end
            // hold the result until taken, load the next one when free
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_ch <= i_channel;
                r_b0 <= i_first_byte;
                r_b1 <= i_second_byte;
            end
            S_DECODE: begin
                r_res_acc  <= ch_ok & smp_ok;
                r_res_sw   <= ch_ok & ~le_ok & sw_ok;
                r_res_held <= ch_ok ? r_held[ch_idx] : '0;
                r_m        <= m_sat;
                r_pp       <= pp;
                r_den_zero <= (den == '0);
                r_wpos     <= pos_adj;
                r_addr     <= {ch_idx, pos_adj};
            end
            S_KDIV: begin
                r_up   <= (r_m >= x_cur);
                r_diff <= (r_m >= x_cur) ? (r_m - x_cur) : (x_cur - r_m);
                if (div_done) begin
                    if (r_den_zero) begin
                        r_k <= '0;
                    end else begin
                        r_k <= (k_quo > ONE_Q16) ? ONE_Q16 : k_quo;
                    end
                end
            end
            S_EST: begin
                r_prod <= mul_p;
            end
            S_COV: begin
                r_xn   <= x_new;
                r_prod <= mul_p;
            end
            S_AVG: begin
                if (div_done) begin
                    r_avg <= (|div_quo[SUM_W-1:DIST_W]) ? DIST_SAT : div_quo[DIST_W-1:0];
                end
            end
            S_BL1: begin
                r_prod <= mul_p;
            end
            S_BL2: begin
                r_acc  <= r_prod[31:0];
                r_prod <= mul_p;
            end
            S_BL3: begin
                r_res_held <= blend[BLEND_SH+DIST_W-1:BLEND_SH];
            end
            default: ;
        endcase
        if (out_load) begin
            r_o_ch   <= r_ch;
            r_o_held <= r_res_held;
            r_o_acc  <= r_res_acc;
            r_o_sw   <= r_res_sw;
        end
    end

    assign o_valid           = r_o_valid;
    assign o_out_channel     = r_o_ch;
    assign o_held_distance   = r_o_held;
    assign o_sample_accepted = r_o_acc;
    assign o_bytes_swapped   = r_o_sw;

endmodule

### design/rsf_checker.sv
// ----------------------------------------------------------------------------
// rsf_checker: port-level checks of the ranging sample filter chain
// Watches the request and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module rsf_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [rsf_pkg::CH_W-1:0]   o_out_channel,
    input logic [rsf_pkg::DIST_W-1:0] o_held_distance,
    input logic                       o_sample_accepted,
    input logic                       o_bytes_swapped
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_held_distance)
                                && $stable(o_out_channel))
        else $error("result changed while stalled");

    // Swapped order only on an accepted sample
    a_swap_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_sample_accepted |-> !o_bytes_swapped)
        else $error("bytes_swapped set on a rejected frame");

    // Reset drops both handshakes while the window store is cleared
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("handshake active straight after reset");

    // One request in flight
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after a request was taken");

endmodule

bind range_sample_filter_chain rsf_checker u_rsf_checker (.*);
